### design/arpc_pkg.sv
// Package with shared constants and types of the ARP cache and responder.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int unsigned IpW  = 32;
  localparam int unsigned MacW = 48;
  localparam int unsigned OpW  = 16;
  localparam int unsigned ActW = 2;

  localparam logic [OpW-1:0] OpRequest = 16'd1;
  localparam logic [OpW-1:0] OpReply   = 16'd2;

  localparam logic [ActW-1:0] ActNone     = 2'd0;
  localparam logic [ActW-1:0] ActUpdated  = 2'd1;
  localparam logic [ActW-1:0] ActInserted = 2'd2;
  localparam logic [ActW-1:0] ActDropped  = 2'd3;

  localparam logic RegOwnIp  = 1'b0;
  localparam logic RegOwnMac = 1'b1;

  typedef struct packed {
    logic            en;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } arpc_wr_t;

endpackage

### design/arpc_table.sv
// Binding table: IP and MAC memories with registered reads and per-entry valid bits.
`timescale 1ns / 1ps

module arpc_table
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IdxW    = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [IpW-1:0]  rd_ip_o,
  output logic [MacW-1:0] rd_mac_o,
  output logic            rd_valid_o,
  input  arpc_wr_t        wr_i,
  input  logic [IdxW-1:0] wr_addr_i
);

  logic [IpW-1:0]     ip_mem  [ENTRIES];
  logic [MacW-1:0]    mac_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [IpW-1:0]     rd_ip_q;
  logic [MacW-1:0]    rd_mac_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      ip_mem[wr_addr_i]  <= wr_i.ip;
      mac_mem[wr_addr_i] <= wr_i.mac;
    end
    if (rd_en_i) begin
      rd_ip_q  <= ip_mem[rd_addr_i];
      rd_mac_q <= mac_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_ip_o    = rd_ip_q;
  assign rd_mac_o   = rd_mac_q;
  assign rd_valid_o = rd_valid_q;

endmodule

### design/arpc_ctrl.sv
// Sequencer that scans the table with one shared comparator and resolves each word.
`timescale 1ns / 1ps

module arpc_ctrl
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CntW    = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic [IpW-1:0]  own_ip_i,
  input  logic            cmd_i,
  input  logic [OpW-1:0]  arp_op_i,
  input  logic [IpW-1:0]  sender_ip_i,
  input  logic [MacW-1:0] sender_mac_i,
  input  logic [IpW-1:0]  target_ip_i,
  input  logic [IpW-1:0]  query_ip_i,
  output logic            done_o,
  output logic            reply_send_o,
  output logic [MacW-1:0] reply_target_mac_o,
  output logic [IpW-1:0]  reply_target_ip_o,
  output logic [ActW-1:0] cache_action_o,
  output logic            found_o,
  output logic [MacW-1:0] found_mac_o,
  output logic            rd_en_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  logic [IpW-1:0]  rd_ip_i,
  input  logic [MacW-1:0] rd_mac_i,
  input  logic            rd_valid_i,
  output arpc_wr_t        wr_o,
  output logic [IdxW-1:0] wr_addr_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StResolve
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [MacW-1:0] hit_mac_q, hit_mac_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [IpW-1:0]  key_q, key_d;
  logic [MacW-1:0] mac_q, mac_d;
  logic            reply_q, reply_d;
  logic            learn_q, learn_d;
  logic            lookup_q, lookup_d;
  logic            done_q, done_d;
  logic            rs_q, rs_d;
  logic [MacW-1:0] rtm_q, rtm_d;
  logic [IpW-1:0]  rti_q, rti_d;
  logic [ActW-1:0] act_q, act_d;
  logic            found_q, found_d;
  logic [MacW-1:0] fmac_q, fmac_d;

  logic rd_en;
  logic match;
  logic last;
  logic is_learn;

  assign rd_en    = (state_q == StScan) && (rd_cnt_q < CntW'(ENTRIES));
  assign match    = rd_valid_i && (rd_ip_i == key_q);
  assign last     = chk_idx_q == IdxW'(ENTRIES - 1);
  assign is_learn = !cmd_i && ((arp_op_i == OpRequest) || (arp_op_i == OpReply));

  always_comb begin
    state_d    = state_q;
    rd_cnt_d   = rd_cnt_q;
    chk_vld_d  = chk_vld_q;
    chk_idx_d  = chk_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_mac_d  = hit_mac_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    key_d      = key_q;
    mac_d      = mac_q;
    reply_d    = reply_q;
    learn_d    = learn_q;
    lookup_d   = lookup_q;
    done_d     = 1'b0;
    rs_d       = rs_q;
    rtm_d      = rtm_q;
    rti_d      = rti_q;
    act_d      = act_q;
    found_d    = found_q;
    fmac_d     = fmac_q;
    wr_o.en    = 1'b0;
    wr_o.ip    = key_q;
    wr_o.mac   = mac_q;
    wr_addr_o  = hit_q ? hit_idx_q : free_idx_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          lookup_d  = cmd_i;
          key_d     = cmd_i ? query_ip_i : sender_ip_i;
          mac_d     = sender_mac_i;
          learn_d   = is_learn;
          reply_d   = !cmd_i && (arp_op_i == OpRequest) && (target_ip_i == own_ip_i);
          hit_d     = 1'b0;
          free_d    = 1'b0;
          rd_cnt_d  = '0;
          chk_vld_d = 1'b0;
          state_d   = (cmd_i || is_learn) ? StScan : StResolve;
        end
      end
      StScan: begin
        if (rd_en) begin
          rd_cnt_d = rd_cnt_q + CntW'(1);
        end
        chk_vld_d = rd_en;
        chk_idx_d = rd_cnt_q[IdxW-1:0];
        if (chk_vld_q) begin
          if (match) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
            hit_mac_d = rd_mac_i;
            chk_vld_d = 1'b0;
            state_d   = StResolve;
          end else begin
            if (!rd_valid_i && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
            if (last) begin
              chk_vld_d = 1'b0;
              state_d   = StResolve;
            end
          end
        end
      end
      StResolve: begin
        wr_o.en = learn_q && (hit_q || free_q);
        done_d  = 1'b1;
        rs_d    = reply_q;
        rtm_d   = reply_q ? mac_q : '0;
        rti_d   = reply_q ? key_q : '0;
        if (!learn_q) begin
          act_d = ActNone;
        end else if (hit_q) begin
          act_d = ActUpdated;
        end else if (free_q) begin
          act_d = ActInserted;
        end else begin
          act_d = ActDropped;
        end
        found_d = lookup_q && hit_q;
        fmac_d  = (lookup_q && hit_q) ? hit_mac_q : '0;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      rd_cnt_q   <= '0;
      chk_vld_q  <= 1'b0;
      chk_idx_q  <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_mac_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      key_q      <= '0;
      mac_q      <= '0;
      reply_q    <= 1'b0;
      learn_q    <= 1'b0;
      lookup_q   <= 1'b0;
      done_q     <= 1'b0;
      rs_q       <= 1'b0;
      rtm_q      <= '0;
      rti_q      <= '0;
      act_q      <= ActNone;
      found_q    <= 1'b0;
      fmac_q     <= '0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      chk_vld_q  <= chk_vld_d;
      chk_idx_q  <= chk_idx_d;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      hit_mac_q  <= hit_mac_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
      key_q      <= key_d;
      mac_q      <= mac_d;
      reply_q    <= reply_d;
      learn_q    <= learn_d;
      lookup_q   <= lookup_d;
      done_q     <= done_d;
      rs_q       <= rs_d;
      rtm_q      <= rtm_d;
      rti_q      <= rti_d;
      act_q      <= act_d;
      found_q    <= found_d;
      fmac_q     <= fmac_d;
    end
  end

  assign busy_o             = state_q != StIdle;
  assign rd_en_o            = rd_en;
  assign rd_addr_o          = rd_cnt_q[IdxW-1:0];
  assign done_o             = done_q;
  assign reply_send_o       = rs_q;
  assign reply_target_mac_o = rtm_q;
  assign reply_target_ip_o  = rti_q;
  assign cache_action_o     = act_q;
  assign found_o            = found_q;
  assign found_mac_o        = fmac_q;

  a_done_after_resolve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == StResolve))
    else $error("result strobe without a resolve cycle");

  a_write_only_on_learn : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (state_q == StResolve) && learn_q && !lookup_q)
    else $error("table written outside a learning resolve");

  a_start_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) && start_i |=> state_q != StIdle)
    else $error("accepted word did not start the sequencer");

  a_found_only_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && found_q |-> (act_q == ActNone) && !rs_q)
    else $error("lookup hit reported together with packet results");

endmodule

### design/arp_cache_responder.sv
// Top level of the ARP cache and responder: configuration register, sequencer and table.
// A lookup or a learning packet scans the table and then resolves, stopping the scan
// early on a hit; a packet with another opcode skips the scan and goes straight to resolve.
// The scan reads one table entry per cycle through a single comparator.
// A new word is accepted in the cycle its predecessor's result is strobed.
// Reset clears all valid bits at once and sets own_ip to zero; no clearing pass.
`timescale 1ns / 1ps

module arp_cache_responder
  import arpc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [MacW-1:0] cfg_wdata_i,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            cmd_i,
  input  logic [OpW-1:0]  arp_op_i,
  input  logic [IpW-1:0]  sender_ip_i,
  input  logic [MacW-1:0] sender_mac_i,
  input  logic [IpW-1:0]  target_ip_i,
  input  logic [IpW-1:0]  query_ip_i,
  output logic            done_o,
  output logic            reply_send_o,
  output logic [MacW-1:0] reply_target_mac_o,
  output logic [IpW-1:0]  reply_target_ip_o,
  output logic [ActW-1:0] cache_action_o,
  output logic            found_o,
  output logic [MacW-1:0] found_mac_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [IpW-1:0]  own_ip_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [IpW-1:0]  rd_ip;
  logic [MacW-1:0] rd_mac;
  logic            rd_valid;
  arpc_wr_t        wr;
  logic [IdxW-1:0] wr_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == RegOwnIp)) begin
      own_ip_q <= cfg_wdata_i[IpW-1:0];
    end
  end

  arpc_ctrl #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .own_ip_i           (own_ip_q),
    .cmd_i              (cmd_i),
    .arp_op_i           (arp_op_i),
    .sender_ip_i        (sender_ip_i),
    .sender_mac_i       (sender_mac_i),
    .target_ip_i        (target_ip_i),
    .query_ip_i         (query_ip_i),
    .done_o             (done_o),
    .reply_send_o       (reply_send_o),
    .reply_target_mac_o (reply_target_mac_o),
    .reply_target_ip_o  (reply_target_ip_o),
    .cache_action_o     (cache_action_o),
    .found_o            (found_o),
    .found_mac_o        (found_mac_o),
    .rd_en_o            (rd_en),
    .rd_addr_o          (rd_addr),
    .rd_ip_i            (rd_ip),
    .rd_mac_i           (rd_mac),
    .rd_valid_i         (rd_valid),
    .wr_o               (wr),
    .wr_addr_o          (wr_addr)
  );

  arpc_table #(
    .ENTRIES (ENTRIES),
    .IdxW    (IdxW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_ip_o    (rd_ip),
    .rd_mac_o   (rd_mac),
    .rd_valid_o (rd_valid),
    .wr_i       (wr),
    .wr_addr_i  (wr_addr)
  );

endmodule

### tb/arp_cache_responder_test.sv
// Self-checking testbench of the ARP cache and responder with its own table predictor.
`timescale 1ns / 1ps

module arp_cache_responder_test;
  import arpc_pkg::*;

  localparam int unsigned Entries  = 16;
  localparam int unsigned Limit    = 300000;
  localparam int unsigned MaxShown = 40;
  localparam int unsigned PoolSize = 24;

  typedef struct {
    logic            reply_send;
    logic [MacW-1:0] reply_mac;
    logic [IpW-1:0]  reply_ip;
    logic [ActW-1:0] action;
    logic            found;
    logic [MacW-1:0] found_mac;
  } arp_result_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [MacW-1:0] cfg_wdata_i;
  logic            start_i;
  logic            busy_o;
  logic            cmd_i;
  logic [OpW-1:0]  arp_op_i;
  logic [IpW-1:0]  sender_ip_i;
  logic [MacW-1:0] sender_mac_i;
  logic [IpW-1:0]  target_ip_i;
  logic [IpW-1:0]  query_ip_i;
  logic            done_o;
  logic            reply_send_o;
  logic [MacW-1:0] reply_target_mac_o;
  logic [IpW-1:0]  reply_target_ip_o;
  logic [ActW-1:0] cache_action_o;
  logic            found_o;
  logic [MacW-1:0] found_mac_o;

  logic [IpW-1:0]  own_ip_q;
  logic [MacW-1:0] own_mac_q;
  logic [IpW-1:0]  cache_ip[Entries];
  logic [MacW-1:0] cache_mac[Entries];
  logic            cache_valid[Entries];
  logic [IpW-1:0]  ip_pool[PoolSize];

  arp_result_t pending_results[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          burst_mode;

  arp_cache_responder #(
    .ENTRIES(Entries)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .cmd_i             (cmd_i),
    .arp_op_i          (arp_op_i),
    .sender_ip_i       (sender_ip_i),
    .sender_mac_i      (sender_mac_i),
    .target_ip_i       (target_ip_i),
    .query_ip_i        (query_ip_i),
    .done_o            (done_o),
    .reply_send_o      (reply_send_o),
    .reply_target_mac_o(reply_target_mac_o),
    .reply_target_ip_o (reply_target_ip_o),
    .cache_action_o    (cache_action_o),
    .found_o           (found_o),
    .found_mac_o       (found_mac_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [MacW-1:0] rand_mac();
    return {16'($urandom_range(0, 16'hffff)), $urandom()};
  endfunction

  function automatic int find_binding(input logic [IpW-1:0] ip);
    for (int i = 0; i < Entries; i++) begin
      if (cache_valid[i] && cache_ip[i] == ip) return i;
    end
    return -1;
  endfunction

  function automatic logic [ActW-1:0] learn_binding(input logic [IpW-1:0] ip,
                                                    input logic [MacW-1:0] mac);
    int k;
    k = find_binding(ip);
    if (k >= 0) begin
      cache_mac[k] = mac;
      return ActUpdated;
    end
    for (int i = 0; i < Entries; i++) begin
      if (!cache_valid[i]) begin
        cache_ip[i]    = ip;
        cache_mac[i]   = mac;
        cache_valid[i] = 1'b1;
        return ActInserted;
      end
    end
    return ActDropped;
  endfunction

  function automatic arp_result_t predict_arp(input logic cmd, input logic [OpW-1:0] op,
                                              input logic [IpW-1:0] sip,
                                              input logic [MacW-1:0] smac,
                                              input logic [IpW-1:0] tip,
                                              input logic [IpW-1:0] qip);
    arp_result_t r;
    int k;
    r = '{1'b0, '0, '0, ActNone, 1'b0, '0};
    if (!cmd) begin
      if (op == OpRequest && tip == own_ip_q) begin
        r.reply_send = 1'b1;
        r.reply_mac  = smac;
        r.reply_ip   = sip;
      end
      if (op == OpRequest || op == OpReply) r.action = learn_binding(sip, smac);
    end else begin
      k = find_binding(qip);
      if (k >= 0) begin
        r.found     = 1'b1;
        r.found_mac = cache_mac[k];
      end
    end
    return r;
  endfunction

  function automatic bit cache_full();
    for (int i = 0; i < Entries; i++) begin
      if (!cache_valid[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxShown) begin
      $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin
    arp_result_t e;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with no pending expectation", '0, '0);
      end else begin
        e = pending_results.pop_front();
        if (reply_send_o !== e.reply_send)
          report_mismatch("reply_send", 64'(e.reply_send), 64'(reply_send_o));
        if (reply_target_mac_o !== e.reply_mac)
          report_mismatch("reply_target_mac", 64'(e.reply_mac), 64'(reply_target_mac_o));
        if (reply_target_ip_o !== e.reply_ip)
          report_mismatch("reply_target_ip", 64'(e.reply_ip), 64'(reply_target_ip_o));
        if (cache_action_o !== e.action)
          report_mismatch("cache_action", 64'(e.action), 64'(cache_action_o));
        if (found_o !== e.found)
          report_mismatch("found", 64'(e.found), 64'(found_o));
        if (found_mac_o !== e.found_mac)
          report_mismatch("found_mac", 64'(e.found_mac), 64'(found_mac_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == Limit) begin
      $display("** arp_cache_responder: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [OpW-1:0] op,
                           input logic [IpW-1:0] sip, input logic [MacW-1:0] smac,
                           input logic [IpW-1:0] tip, input logic [IpW-1:0] qip,
                           input int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i        <= cmd;
    arp_op_i     <= op;
    sender_ip_i  <= sip;
    sender_mac_i <= smac;
    target_ip_i  <= tip;
    query_ip_i   <= qip;
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_arp(cmd, op, sip, smac, tip, qip));
  endtask

  task automatic send_packet(input logic [OpW-1:0] op, input logic [IpW-1:0] sip,
                             input logic [MacW-1:0] smac, input logic [IpW-1:0] tip);
    send_word(1'b0, op, sip, smac, tip, $urandom(), pick_gap());
  endtask

  task automatic send_lookup(input logic [IpW-1:0] qip);
    send_word(1'b1, OpW'($urandom_range(0, 16'hffff)), $urandom(), rand_mac(), $urandom(),
              qip, pick_gap());
  endtask

  task automatic drain_pending();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Entries + 4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [IpW-1:0] ip, input logic [MacW-1:0] mac);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegOwnIp;
    cfg_wdata_i <= {16'($urandom_range(0, 16'hffff)), ip};
    @(posedge clk_i);
    cfg_idx_i   <= RegOwnMac;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    own_ip_q  = ip;
    own_mac_q = mac;
  endtask

  task automatic test_empty_lookup();
    send_lookup('0);
    send_lookup('1);
  endtask

  task automatic test_packet_opcodes();
    logic [IpW-1:0] me;
    me = 32'hc0a8_0101;
    drain_pending();
    set_config(me, 48'h02_00_00_00_00_01);
    send_packet(OpRequest, '0, '1, me);
    send_packet(OpReply, '1, '0, '0);
    send_packet(OpRequest, 32'h0a00_0005, 48'h1234_5678_9abc, 32'h0a00_0001);
    send_packet('0, 32'h0a00_0006, rand_mac(), me);
    send_packet('1, 32'h0a00_0007, rand_mac(), me);
    send_packet(16'd3, 32'h0a00_0008, rand_mac(), me);
    send_lookup(32'h0a00_0006);
    send_packet(OpRequest, '0, 48'h5555_aaaa_5555, me);
    send_packet(OpReply, 32'h0a00_0005, 48'haaaa_5555_aaaa, me);
    send_lookup('0);
    send_lookup('1);
    send_lookup(32'h0a00_0005);
    send_word(1'b1, OpRequest, me, '1, me, 32'h0a00_0005, 0);
    send_word(1'b0, OpRequest, 32'h0a00_0009, rand_mac(), me, '1, 0);
  endtask

  task automatic test_random_phase(input logic [IpW-1:0] ip, input logic [MacW-1:0] mac,
                                   input int n);
    int unsigned r;
    logic [IpW-1:0] sip;
    logic [IpW-1:0] tip;
    logic [OpW-1:0] op;
    drain_pending();
    set_config(ip, mac);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 24) == 0) drain_pending();
      sip = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, PoolSize - 1)]
                                         : $urandom();
      r = $urandom_range(0, 2);
      tip = (r == 0) ? own_ip_q : (r == 1) ? ip_pool[$urandom_range(0, PoolSize - 1)]
                                           : $urandom();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_lookup(($urandom_range(0, 99) < 75) ? ip_pool[$urandom_range(0, PoolSize - 1)]
                                                 : $urandom());
      end else begin
        op = (r < 60) ? OpRequest : (r < 88) ? OpReply : OpW'($urandom_range(0, 16'hffff));
        send_packet(op, sip, rand_mac(), tip);
      end
    end
  endtask

  task automatic test_table_full();
    logic [IpW-1:0] me;
    me = own_ip_q;
    for (int i = 0; i < Entries + 4 && !cache_full(); i++) begin
      send_packet(OpReply, $urandom(), rand_mac(), $urandom());
    end
    send_packet(OpRequest, 32'h7f00_0001, rand_mac(), me);
    send_packet(OpReply, 32'h7f00_0002, rand_mac(), me);
    send_packet(OpRequest, cache_ip[Entries - 1], rand_mac(), me);
    send_lookup(cache_ip[Entries - 1]);
    send_lookup(cache_ip[0]);
    send_lookup(32'h7f00_0001);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegOwnIp;
    cfg_wdata_i  = '0;
    start_i      = 1'b0;
    cmd_i        = 1'b0;
    arp_op_i     = '0;
    sender_ip_i  = '0;
    sender_mac_i = '0;
    target_ip_i  = '0;
    query_ip_i   = '0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    burst_mode   = 1'b0;
    own_ip_q     = '0;
    own_mac_q    = '0;
    for (int i = 0; i < Entries; i++) begin
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
      cache_valid[i] = 1'b0;
    end
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) ip_pool[i] = $urandom();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookup();
    test_packet_opcodes();
    test_random_phase('0, '0, 175);
    test_random_phase('1, '1, 175);
    test_random_phase($urandom(), rand_mac(), 175);
    test_random_phase(ip_pool[$urandom_range(2, PoolSize - 1)], rand_mac(), 175);
    test_table_full();

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Entries + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** arp_cache_responder: PASSED **");
    end else begin
      $display("** arp_cache_responder: FAILED **");
    end
    $finish;
  end

endmodule
